// ===== sv/protected_id_access_filter_core_defines.svh =====
// Assertion macros for the protected ID access filter.
`ifndef PROTECTED_ID_ACCESS_FILTER_CORE_DEFINES_SVH
`define PROTECTED_ID_ACCESS_FILTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked under reset disable.
`define PIDAF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked at every edge, reset included.
`define PIDAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIDAF_ASSERT(lbl, clk, rstn, prop, msg)
`define PIDAF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/pidaf_pkg.sv =====
package pidaf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ID_W    = 32;
  localparam int ACC_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;
  localparam int CHG_W   = 9;
  localparam int ENTRY_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_CHECK  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    IS_OK       = 3'd0,
    IS_ZERO_ID  = 3'd1,
    IS_FULL     = 3'd2,
    IS_ADD_FAIL = 3'd3,
    IS_SKIPPED  = 3'd4
  } item_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [STAT_W-1:0]  item_status;
    logic [REQ_W-1:0]   request_status;
    logic [CHG_W-1:0]   changed_total;
    logic [ACC_W-1:0]   access_out;
    logic [ENTRY_W-1:0] entry_count;
    logic               was_listed;
  } result_t;

endpackage

// ===== sv/pidaf_ifs.sv =====
interface pidaf_in_if;
  logic                           valid;
  logic                           ready;
  logic [pidaf_pkg::FUNC_W-1:0]   func;
  logic [pidaf_pkg::ID_W-1:0]     ident;
  logic                           kernel_open;
  logic [pidaf_pkg::ACC_W-1:0]    access_in;
  logic                           last_of_request;

  modport source (output valid, func, ident, kernel_open, access_in, last_of_request,
                  input ready);
  modport sink (input valid, func, ident, kernel_open, access_in, last_of_request,
                output ready);
endinterface

interface pidaf_out_if;
  logic                           valid;
  logic                           ready;
  logic [pidaf_pkg::STAT_W-1:0]   item_status;
  logic [pidaf_pkg::REQ_W-1:0]    request_status;
  logic [pidaf_pkg::CHG_W-1:0]    changed_total;
  logic [pidaf_pkg::ACC_W-1:0]    access_out;
  logic [pidaf_pkg::ENTRY_W-1:0]  entry_count;
  logic                           was_listed;

  modport source (output valid, item_status, request_status, changed_total, access_out,
                  entry_count, was_listed, input ready);
  modport sink (input valid, item_status, request_status, changed_total, access_out,
                entry_count, was_listed, output ready);
endinterface

// ===== sv/protected_id_access_filter_core.sv =====
// Protected ID access filter core.
// Input channel in_chan (valid/ready): one operation per transfer; func selects
// add, remove, clear or check, with ident, kernel_open, access_in and
// last_of_request. Output channel out_chan (valid/ready): exactly one result
// transfer per input transfer, in order. cfg_we/cfg_wdata write strip_mask.
// Clear, check of ID zero and skipped or zero-ID add/remove skip the table scan
// and go straight to commit. Every other item scans the whole ID table through
// the single read port of the table RAM, one entry per cycle, then passes the
// compare tail state before commit. One item is in work at a time; in_chan.ready
// is high only while the controller is idle.
// Reset (rst_n, synchronous): table empty through its valid bits, count and
// batch state zero, strip_mask = 1. No clearing pass is needed.
// Stall: the result sits in an output register; the next item is accepted
// while it waits, and that item's commit holds until out_chan.ready drains it.
module protected_id_access_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  pidaf_in_if.sink                      in_chan,
  pidaf_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [pidaf_pkg::ACC_W-1:0]   cfg_wdata
);

  pidaf_pkg::cmd_t    cmd;
  pidaf_pkg::sts_t    sts;
  pidaf_pkg::result_t res;
  logic               in_ready;
  logic               out_valid;

  // sequencer: idle / table scan / compare tail / commit
  pidaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table RAM, scan trackers, batch state and result register
  pidaf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_chan.func),
    .in_ident           (in_chan.ident),
    .in_kernel_open     (in_chan.kernel_open),
    .in_access_in       (in_chan.access_in),
    .in_last_of_request (in_chan.last_of_request),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_chan.ready),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_item           (res)
  );

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid;
  assign out_chan.item_status    = res.item_status;
  assign out_chan.request_status = res.request_status;
  assign out_chan.changed_total  = res.changed_total;
  assign out_chan.access_out     = res.access_out;
  assign out_chan.entry_count    = res.entry_count;
  assign out_chan.was_listed     = res.was_listed;

endmodule

// ===== sv/pidaf_ctrl.sv =====
module pidaf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pidaf_pkg::sts_t   sts,
  output pidaf_pkg::cmd_t   cmd
);

  pidaf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidaf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pidaf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_scan ? pidaf_pkg::S_SCAN : pidaf_pkg::S_DONE;
        end
      end
      pidaf_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = pidaf_pkg::S_TAIL;
        end
      end
      pidaf_pkg::S_TAIL: begin
        // last read data lands in the compare stage
        state_nxt = pidaf_pkg::S_DONE;
      end
      pidaf_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = pidaf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pidaf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pidaf_datapath.sv =====
`include "protected_id_access_filter_core_defines.svh"

module pidaf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pidaf_pkg::FUNC_W-1:0]   in_func,
  input  logic [pidaf_pkg::ID_W-1:0]     in_ident,
  input  logic                           in_kernel_open,
  input  logic [pidaf_pkg::ACC_W-1:0]    in_access_in,
  input  logic                           in_last_of_request,
  input  logic                           cfg_we,
  input  logic [pidaf_pkg::ACC_W-1:0]    cfg_wdata,
  input  logic                           out_ready,
  input  pidaf_pkg::cmd_t                cmd,
  output pidaf_pkg::sts_t                sts,
  output logic                           out_valid,
  output pidaf_pkg::result_t             out_item
);

  localparam int N = pidaf_pkg::TABLE_ENTRIES;
  localparam int IW = pidaf_pkg::IDX_W;

  // held item
  pidaf_pkg::func_t                 func_r;
  logic [pidaf_pkg::ID_W-1:0]       id_r;
  logic                             kern_r;
  logic [pidaf_pkg::ACC_W-1:0]      acc_r;
  logic                             last_r;

  // table storage, valid bits stand for "nonzero"
  logic [pidaf_pkg::ID_W-1:0]       mem [N];
  logic [N-1:0]                     vld_r;

  // scan pipeline
  logic [IW-1:0]                    cnt_r;
  logic [IW-1:0]                    pidx_r;
  logic                             pend_r;
  logic [pidaf_pkg::ID_W-1:0]       rdata_r;
  logic                             rvld_r;
  logic                             found_r;
  logic [IW-1:0]                    found_idx_r;
  logic                             free_found_r;
  logic [IW-1:0]                    free_idx_r;

  // persistent state
  logic [pidaf_pkg::CNT_W-1:0]      held_r, held_nxt;
  logic                             stop_r, stop_nxt;
  logic [pidaf_pkg::REQ_W-1:0]      err_r, err_nxt;
  logic [pidaf_pkg::CHG_W-1:0]      chg_r, chg_nxt;
  logic [pidaf_pkg::ACC_W-1:0]      strip_r;

  // commit decode
  pidaf_pkg::result_t               res;
  logic                             wr_en;
  logic                             vld_clr_one;
  logic                             vld_clr_all;
  logic                             out_valid_r;
  pidaf_pkg::result_t               out_r;
  logic                             hit;
  logic                             in_zero;
  logic                             need_scan;
  logic                             batch_close;

  assign in_zero = (in_ident == '0);

  always_comb begin
    unique case (pidaf_pkg::func_t'(in_func))
      pidaf_pkg::FN_CHECK:  need_scan = !in_zero;
      pidaf_pkg::FN_CLEAR:  need_scan = 1'b0;
      pidaf_pkg::FN_ADD,
      pidaf_pkg::FN_REMOVE: need_scan = !stop_r && !in_zero;
      default:              need_scan = 1'b0;
    endcase
  end

  assign sts = '{need_scan: need_scan,
                 scan_last: (cnt_r == IW'(N - 1)),
                 out_free:  (!out_valid_r || out_ready)};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= pidaf_pkg::func_t'(in_func);
      id_r   <= in_ident;
      kern_r <= in_kernel_open;
      acc_r  <= in_access_in;
      last_r <= in_last_of_request;
    end
  end

  // one read per scan cycle, one write at commit
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rdata_r <= mem[cnt_r];
      rvld_r  <= vld_r[cnt_r];
      pidx_r  <= cnt_r;
    end
    if (wr_en) begin
      mem[free_idx_r] <= id_r;
    end
  end

  assign hit = pend_r && rvld_r && (rdata_r == id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_step;
      if (cmd.load) begin
        cnt_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (hit && !found_r) begin
          found_r <= 1'b1;
        end
        if (pend_r && !rvld_r && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && !found_r) begin
      found_idx_r <= pidx_r;
    end
    if (pend_r && !rvld_r && !free_found_r) begin
      free_idx_r <= pidx_r;
    end
  end

  always_comb begin
    res         = '0;
    held_nxt    = held_r;
    stop_nxt    = stop_r;
    err_nxt     = err_r;
    chg_nxt     = chg_r;
    wr_en       = 1'b0;
    vld_clr_one = 1'b0;
    vld_clr_all = 1'b0;
    unique case (func_r)
      pidaf_pkg::FN_CLEAR: begin
        vld_clr_all = cmd.commit;
        held_nxt    = '0;
      end
      pidaf_pkg::FN_CHECK: begin
        res.was_listed = found_r;
        res.access_out = (!kern_r && found_r) ? (acc_r & ~strip_r) : acc_r;
      end
      pidaf_pkg::FN_ADD,
      pidaf_pkg::FN_REMOVE: begin
        if (stop_r) begin
          res.item_status = pidaf_pkg::IS_SKIPPED;
        end else if (id_r == '0) begin
          res.item_status = pidaf_pkg::IS_ZERO_ID;
          if (err_r == '0) begin
            err_nxt = pidaf_pkg::REQ_W'(pidaf_pkg::IS_ZERO_ID);
          end
          stop_nxt = 1'b1;
        end else if (func_r == pidaf_pkg::FN_ADD) begin
          if (found_r) begin
            res.was_listed = 1'b1;
          end else if (held_r >= pidaf_pkg::CNT_W'(N)) begin
            res.item_status = pidaf_pkg::IS_FULL;
            if (err_r == '0) begin
              err_nxt = pidaf_pkg::REQ_W'(pidaf_pkg::IS_FULL);
            end
            stop_nxt = 1'b1;
          end else if (!free_found_r) begin
            res.item_status = pidaf_pkg::IS_ADD_FAIL;
            if (err_r == '0) begin
              err_nxt = pidaf_pkg::REQ_W'(pidaf_pkg::IS_ADD_FAIL);
            end
            stop_nxt = 1'b1;
          end else begin
            wr_en    = cmd.commit;
            held_nxt = held_r + 1'b1;
            chg_nxt  = (chg_r != '1) ? chg_r + 1'b1 : chg_r;
          end
        end else begin
          if (found_r) begin
            res.was_listed = 1'b1;
            vld_clr_one    = cmd.commit;
            held_nxt       = (held_r != '0) ? held_r - 1'b1 : held_r;
            chg_nxt        = (chg_r != '1) ? chg_r + 1'b1 : chg_r;
            if (held_nxt == '0) begin
              stop_nxt = 1'b1;
            end
          end
        end
        res.request_status = err_nxt;
        res.changed_total  = chg_nxt;
        if (last_r) begin
          stop_nxt = 1'b0;
          err_nxt  = '0;
          chg_nxt  = '0;
        end
      end
      default: begin
        held_nxt = held_r;
      end
    endcase
    res.entry_count = pidaf_pkg::ENTRY_W'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      held_r      <= '0;
      stop_r      <= 1'b0;
      err_r       <= '0;
      chg_r       <= '0;
      strip_r     <= pidaf_pkg::ACC_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        strip_r <= cfg_wdata;
      end
      if (vld_clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[free_idx_r] <= 1'b1;
      end else if (vld_clr_one) begin
        vld_r[found_idx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        held_r      <= held_nxt;
        stop_r      <= stop_nxt;
        err_r       <= err_nxt;
        chg_r       <= chg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // commit of the last add/remove of a batch
  assign batch_close = cmd.commit && last_r &&
                       (func_r == pidaf_pkg::FN_ADD || func_r == pidaf_pkg::FN_REMOVE);

  `PIDAF_ASSERT(a_held_bound, clk, rst_n, held_r <= pidaf_pkg::CNT_W'(N), "held count above table size")
  `PIDAF_ASSERT(a_commit_room, clk, rst_n, cmd.commit |-> sts.out_free, "commit overwrites result")
  `PIDAF_ASSERT(a_batch_end, clk, rst_n, batch_close |=> (!stop_r && err_r == '0 && chg_r == '0), "batch not cleared")
  `PIDAF_ASSERT(a_add_bumps, clk, rst_n, wr_en |=> (held_r == $past(held_r) + 1'b1), "add did not bump held count")

endmodule

// ===== sim/tb_protected_id_access_filter_core.sv =====
`timescale 1ns / 1ps

module tb_protected_id_access_filter_core;
  import pidaf_pkg::*;

  // No transfer on either channel for this long ends the run.
  // The slowest item scans the whole table, and random gaps are short.
  localparam int QUIET_LIMIT = 4000;
  // Drain time after the last result, about one full table scan.
  localparam int TAIL_CYCLES = 300;
  localparam int PHASES      = 4;

  // One operation as driven on in_chan. If has_want is set, want is the
  // result typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    func_t        fn;
    logic [31:0]  ident;
    logic         kern;
    logic [31:0]  acc;
    logic         last;
    logic         has_want;
    result_t      want;
  } op_row_t;

  // Directed operations, run with strip_mask = 1 from reset.
  localparam op_row_t DIRECTED_OPS [21] = '{
    // check of ID zero on an empty table passes access through
    '{FN_CHECK, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{IS_OK, 2'd0, 9'd0, 32'hFFFF_FFFF, 9'd0, 1'b0}},
    // zero ID on add: error 1, batch stops
    '{FN_ADD, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1,
      '{IS_ZERO_ID, 2'd1, 9'd0, 32'h0, 9'd0, 1'b0}},
    // rest of the batch is skipped; last closes it
    '{FN_ADD, 32'h5, 1'b0, 32'h0, 1'b1, 1'b1,
      '{IS_SKIPPED, 2'd1, 9'd0, 32'h0, 9'd0, 1'b0}},
    '{FN_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b1,
      '{IS_OK, 2'd0, 9'd1, 32'h0, 9'd1, 1'b0}},
    // duplicate add: ok, listed, nothing changes
    '{FN_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b1,
      '{IS_OK, 2'd0, 9'd1, 32'h0, 9'd1, 1'b1}},
    '{FN_ADD, 32'h1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{IS_OK, 2'd0, 9'd2, 32'h0, 9'd2, 1'b0}},
    // user open of a listed ID loses bit 0
    '{FN_CHECK, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{IS_OK, 2'd0, 9'd0, 32'hFFFF_FFFE, 9'd2, 1'b1}},
    // kernel open keeps everything, still reports listed
    '{FN_CHECK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{IS_OK, 2'd0, 9'd0, 32'hFFFF_FFFF, 9'd2, 1'b1}},
    '{FN_CHECK, 32'h2, 1'b0, 32'h0001_2345, 1'b0, 1'b0, '0},
    // empty slots never match ID zero
    '{FN_CHECK, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{IS_OK, 2'd0, 9'd0, 32'hFFFF_FFFF, 9'd2, 1'b0}},
    '{FN_REMOVE, 32'h0, 1'b0, 32'h0, 1'b1, 1'b1,
      '{IS_ZERO_ID, 2'd1, 9'd0, 32'h0, 9'd2, 1'b0}},
    // unlisted remove, then two removes that empty the table
    '{FN_REMOVE, 32'h7, 1'b0, 32'h0, 1'b0, 1'b0, '0},
    '{FN_REMOVE, 32'h1, 1'b1, 32'h0, 1'b0, 1'b0, '0},
    '{FN_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0, '0},
    // skipped: batch stopped by the empty table, no error code
    '{FN_ADD, 32'h9, 1'b0, 32'h0, 1'b1, 1'b0, '0},
    '{FN_ADD, 32'h3, 1'b0, 32'h0, 1'b0, 1'b0, '0},
    // clear mid-batch leaves batch state alone
    '{FN_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{IS_OK, 2'd0, 9'd0, 32'h0, 9'd0, 1'b0}},
    '{FN_ADD, 32'h4, 1'b0, 32'h0, 1'b1, 1'b0, '0},
    '{FN_CHECK, 32'h4, 1'b0, 32'h3, 1'b1, 1'b0, '0},
    '{FN_REMOVE, 32'h4, 1'b0, 32'h0, 1'b1, 1'b0, '0},
    '{FN_ADD, 32'h8000_0000, 1'b1, 32'h0, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ACC_W-1:0] cfg_wdata;

  pidaf_in_if  in_chan_if ();
  pidaf_out_if out_chan_if ();

  protected_id_access_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan_if),
    .out_chan  (out_chan_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted filter state, mirrors the block from reset.
  // ---------------------------------------------------------------------------
  logic [31:0] id_store [TABLE_ENTRIES] = '{default: '0};
  int          held          = 0;
  logic        batch_halted  = 1'b0;
  logic [1:0]  batch_err     = 2'd0;
  int          batch_changes = 0;
  logic [31:0] strip_mask    = 32'h1;

  result_t pending_results [$];   // one entry per accepted operation, in order
  int      ops_sent       = 0;
  int      results_seen   = 0;
  int      mismatch_count = 0;
  int      full_hits      = 0;
  int      sat_hits       = 0;
  int      peak_held      = 0;
  int      send_idle_pct  = 0;
  int      sink_stall_pct = 0;
  int      quiet_cycles   = 0;

  function automatic int find_id(input logic [31:0] id);
    if (id == '0) return -1;
    foreach (id_store[i]) begin
      if (id_store[i] == id) return i;
    end
    return -1;
  endfunction

  // First error of a batch sticks; any error stops the batch.
  function automatic void flag_batch_error(input item_stat_t code);
    if (batch_err == 2'd0) batch_err = code[1:0];
    batch_halted = 1'b1;
  endfunction

  // Applies one operation to the predicted state and returns its result.
  function automatic result_t filter_apply(input func_t fn, input logic [31:0] id,
                                           input logic kern, input logic [31:0] acc,
                                           input logic last);
    result_t r;
    int slot;
    int free_slot;
    r = '0;
    if (fn == FN_CLEAR) begin
      foreach (id_store[i]) id_store[i] = '0;
      held = 0;
    end else if (fn == FN_CHECK) begin
      slot = find_id(id);
      r.was_listed = (slot >= 0);
      r.access_out = (!kern && slot >= 0) ? (acc & ~strip_mask) : acc;
    end else begin
      if (batch_halted) begin
        r.item_status = IS_SKIPPED;
      end else if (id == '0) begin
        r.item_status = IS_ZERO_ID;
        flag_batch_error(IS_ZERO_ID);
      end else if (fn == FN_ADD) begin
        slot = find_id(id);
        if (slot >= 0) begin
          r.was_listed = 1'b1;
        end else if (held >= TABLE_ENTRIES) begin
          r.item_status = IS_FULL;
          flag_batch_error(IS_FULL);
        end else begin
          // With the count below full a free slot always exists, so the
          // add-failed branch is kept for fidelity but cannot be reached.
          free_slot = -1;
          foreach (id_store[i]) begin
            if (free_slot < 0 && id_store[i] == '0) free_slot = i;
          end
          if (free_slot < 0) begin
            r.item_status = IS_ADD_FAIL;
            flag_batch_error(IS_ADD_FAIL);
          end else begin
            id_store[free_slot] = id;
            held++;
            if (batch_changes < 511) batch_changes++;
          end
        end
      end else begin
        slot = find_id(id);
        if (slot >= 0) begin
          r.was_listed = 1'b1;
          id_store[slot] = '0;
          if (held > 0) held--;
          if (batch_changes < 511) batch_changes++;
          // emptying the table stops the batch without an error code
          if (held == 0) batch_halted = 1'b1;
        end
      end
      r.request_status = batch_err;
      r.changed_total  = batch_changes[8:0];
      if (last) begin
        batch_halted  = 1'b0;
        batch_err     = 2'd0;
        batch_changes = 0;
      end
    end
    r.entry_count = held[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic op_row_t mk_op(input func_t fn, input logic [31:0] id, input logic kern,
                                    input logic [31:0] acc, input logic last);
    op_row_t op;
    op = '0;
    op.fn    = fn;
    op.ident = id;
    op.kern  = kern;
    op.acc   = acc;
    op.last  = last;
    return op;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // A random ID that is not in the table; small values make collisions likely.
  function automatic logic [31:0] fresh_id();
    logic [31:0] cand;
    do begin
      case ($urandom_range(9))
        0, 1, 2, 3: cand = $urandom;
        4, 5, 6, 7, 8: cand = $urandom_range(1, 64);
        default: begin
          case ($urandom_range(3))
            0: cand = 32'h1;
            1: cand = 32'hFFFF_FFFF;
            2: cand = 32'h8000_0000;
            default: cand = 32'h7FFF_FFFF;
          endcase
        end
      endcase
    end while (cand == '0 || find_id(cand) >= 0);
    return cand;
  endfunction

  // A random ID currently held; falls back to a random nonzero ID if empty.
  function automatic logic [31:0] listed_id();
    int k;
    int seen;
    if (held == 0) return $urandom | 32'h1;
    k = $urandom_range(held - 1);
    seen = 0;
    foreach (id_store[i]) begin
      if (id_store[i] != '0) begin
        if (seen == k) return id_store[i];
        seen++;
      end
    end
    return 32'h1;
  endfunction

  function automatic logic [31:0] rand_access();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Presents one operation, holds it until the transfer, then predicts.
  task automatic send_op(input op_row_t op);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan_if.valid           <= 1'b1;
    in_chan_if.func            <= op.fn;
    in_chan_if.ident           <= op.ident;
    in_chan_if.kernel_open     <= op.kern;
    in_chan_if.access_in       <= op.acc;
    in_chan_if.last_of_request <= op.last;
    do @(posedge clk); while (in_chan_if.ready !== 1'b1);
    want = filter_apply(op.fn, op.ident, op.kern, op.acc, op.last);
    if (op.has_want) want = op.want;
    pending_results.push_back(want);
    ops_sent++;
    if (want.item_status == IS_FULL) full_hits++;
    if (want.changed_total == 9'd511) sat_hits++;
    if (held > peak_held) peak_held = held;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_drained();
    in_chan_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_strip(input logic [31:0] mask);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we     <= 1'b0;
    strip_mask = mask;
  endtask

  // One long add/remove batch: fill the table, cycle 150 entries out and back
  // in so the change count runs past its 511 ceiling, then hit the full table.
  task automatic saturating_fill_batch();
    int k;
    send_op(mk_op(FN_CLEAR, $urandom, rand_bit(), rand_access(), rand_bit()));
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      send_op(mk_op(FN_ADD, fresh_id(), rand_bit(), rand_access(), 1'b0));
      if (k % 32 == 31)
        send_op(mk_op(FN_ADD, listed_id(), 1'b0, 32'h0, 1'b0));
      if (k % 64 == 63)
        send_op(mk_op(FN_CHECK, listed_id(), 1'b0, 32'hFFFF_FFFF, 1'b1));
    end
    for (k = 0; k < 150; k++)
      send_op(mk_op(FN_REMOVE, listed_id(), rand_bit(), rand_access(), 1'b0));
    for (k = 0; k < 150; k++)
      send_op(mk_op(FN_ADD, fresh_id(), rand_bit(), rand_access(), 1'b0));
    send_op(mk_op(FN_ADD, fresh_id(), 1'b0, 32'h0, 1'b0));      // table full
    send_op(mk_op(FN_REMOVE, listed_id(), 1'b0, 32'h0, 1'b0));  // skipped
    send_op(mk_op(FN_ADD, fresh_id(), 1'b0, 32'h0, 1'b1));      // skipped, closes batch
    send_op(mk_op(FN_CLEAR, 32'h0, 1'b0, 32'h0, 1'b0));
  endtask

  // Mostly well-formed batches with random content, plus checks, clears,
  // table drains and batches left open or cut short.
  task automatic random_traffic(input int n_ops);
    int   stop_at;
    int   pick;
    int   blen;
    int   add_pct;
    int   k;
    logic last;
    logic [31:0] id;
    stop_at = ops_sent + n_ops;
    while (ops_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 2) wait_drained();
      if (pick < 18) begin
        case ($urandom_range(9))
          0: id = 32'h0;
          1, 2, 3, 4: id = $urandom_range(3) == 0 ? $urandom : fresh_id();
          default: id = listed_id();
        endcase
        send_op(mk_op(FN_CHECK, id, rand_bit(), rand_access(), rand_bit()));
      end else if (pick < 22) begin
        send_op(mk_op(FN_CLEAR, $urandom, rand_bit(), rand_access(), rand_bit()));
      end else if (pick < 28 && held <= 6) begin
        // remove everything held; the emptying remove stops the batch.
        // A batch left stopped skips removes, so the trailing items close it.
        while (held > 0 && !batch_halted)
          send_op(mk_op(FN_REMOVE, listed_id(), rand_bit(), rand_access(), 1'b0));
        for (k = $urandom_range(1, 2); k > 0; k--)
          send_op(mk_op(rand_bit() ? FN_ADD : FN_REMOVE, fresh_id(),
                        rand_bit(), rand_access(), k == 1));
      end else begin
        blen = $urandom_range(1, 8);
        for (k = 0; k < blen; k++) begin
          add_pct = (held < 4) ? 80 : (held > 24) ? 30 : 55;
          if (k == blen - 1) last = ($urandom_range(9) != 0);   // sometimes left open
          else last = ($urandom_range(19) == 0);                 // sometimes cut short
          if ($urandom_range(99) < add_pct) begin
            case ($urandom_range(19))
              0: id = 32'h0;
              1, 2: id = listed_id();
              default: id = fresh_id();
            endcase
            send_op(mk_op(FN_ADD, id, rand_bit(), rand_access(), last));
          end else begin
            case ($urandom_range(19))
              0: id = 32'h0;
              1: id = $urandom;
              2, 3, 4, 5: id = $urandom_range(1, 64);
              default: id = listed_id();
            endcase
            send_op(mk_op(FN_REMOVE, id, rand_bit(), rand_access(), last));
          end
          if ($urandom_range(9) == 0)
            send_op(mk_op(FN_CHECK, listed_id(), rand_bit(), rand_access(), rand_bit()));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and field-by-field comparison
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst_n) begin
      out_chan_if.ready <= 1'b0;
    end else begin
      out_chan_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (out_chan_if.valid === 1'b1 && out_chan_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("item_status", 32'(want.item_status),
                      32'(out_chan_if.item_status));
          check_field("request_status", 32'(want.request_status),
                      32'(out_chan_if.request_status));
          check_field("changed_total", 32'(want.changed_total),
                      32'(out_chan_if.changed_total));
          check_field("access_out", want.access_out, out_chan_if.access_out);
          check_field("entry_count", 32'(want.entry_count),
                      32'(out_chan_if.entry_count));
          check_field("was_listed", 32'(want.was_listed),
                      32'(out_chan_if.was_listed));
          results_seen++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_chan_if.valid === 1'b1 && in_chan_if.ready === 1'b1) ||
        (out_chan_if.valid === 1'b1 && out_chan_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] phase_mask [PHASES];
    int          idle_pct [PHASES];
    int          stall_pct [PHASES];
    phase_mask = '{32'hFFFF_FFFF, 32'h0, $urandom, $urandom | 32'h1};
    idle_pct   = '{0, 59, 0, 22};
    stall_pct  = '{0, 0, 59, 22};

    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_wdata                  <= '0;
    in_chan_if.valid           <= 1'b0;
    in_chan_if.func            <= FN_ADD;
    in_chan_if.ident           <= '0;
    in_chan_if.kernel_open     <= 1'b0;
    in_chan_if.access_in       <= '0;
    in_chan_if.last_of_request <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, with the reset mask written back explicitly
    write_strip(32'h1);
    foreach (DIRECTED_OPS[i]) send_op(DIRECTED_OPS[i]);

    // random phases, each with its own mask and idle/stall profile;
    // the first one also carries the long full-table batch
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_strip(phase_mask[ph]);
      send_idle_pct  = idle_pct[ph];
      sink_stall_pct = stall_pct[ph];
      if (ph == 0) saturating_fill_batch();
      random_traffic(215);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("Covered %0d operations (%0d results checked) over %0d idle/stall profiles.",
             ops_sent, results_seen, PHASES);
    $display("Peak occupancy %0d, full-table rejects %0d, saturated change counts %0d.",
             peak_held, full_hits, sat_hits);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
